[rtl/pbsw_pkg.sv]
// ----------------------------------------------------------------------------
// pbsw_pkg
// Shared widths, register map, reset values and types of the sliding-window
// photon burst search.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsw_pkg;

  localparam int TIME_W     = 64;   // photon timestamp
  localparam int OUT_W      = 40;   // reported photon index
  localparam int WP_W       = 7;    // window_photons register
  localparam int MIN_W      = 40;   // min_burst_photons register
  localparam int TICKS_W    = 32;   // window_ticks register
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_SEL_W  = 2;

  // Register select, taken from paddr[4:3] (registers lie 8 bytes apart).
  localparam logic [REG_SEL_W-1:0] REG_WINDOW_PHOTONS = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_MIN_BURST      = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_WINDOW_TICKS   = 2'd2;

  localparam logic [WP_W-1:0]    RST_WINDOW_PHOTONS = 7'd10;
  localparam logic [MIN_W-1:0]   RST_MIN_BURST      = 40'd30;
  localparam logic [TICKS_W-1:0] RST_WINDOW_TICKS   = 32'd1000;

  typedef struct packed {
    logic [WP_W-1:0]    window_photons;
    logic [MIN_W-1:0]   min_burst_photons;
    logic [TICKS_W-1:0] window_ticks;
  } pbsw_cfg_t;

  // Per-photon control bits handed from the front stage to the burst stage.
  typedef struct packed {
    logic full;    // enough photons seen to test a window
    logic eos;     // last photon of the record
    logic m_one;   // window of one photon: span is always zero
  } pbsw_flags_t;

endpackage

`default_nettype wire

[rtl/pbsw_cfg.sv]
// ----------------------------------------------------------------------------
// pbsw_cfg
// APB register file holding the window size, the minimum burst length and
// the window span in ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsw_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pbsw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [pbsw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [pbsw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output pbsw_pkg::pbsw_cfg_t                   cfg
);
  import pbsw_pkg::*;

  pbsw_cfg_t             cfg_r;
  logic [REG_SEL_W-1:0]  sel;
  logic                  wr_en;

  assign sel    = paddr[CFG_ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_photons    <= RST_WINDOW_PHOTONS;
      cfg_r.min_burst_photons <= RST_MIN_BURST;
      cfg_r.window_ticks      <= RST_WINDOW_TICKS;
    end else if (wr_en) begin
      case (sel)
        REG_WINDOW_PHOTONS: cfg_r.window_photons    <= pwdata[WP_W-1:0];
        REG_MIN_BURST:      cfg_r.min_burst_photons <= pwdata[MIN_W-1:0];
        REG_WINDOW_TICKS:   cfg_r.window_ticks      <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_WINDOW_PHOTONS: prdata = CFG_DATA_W'(cfg_r.window_photons);
      REG_MIN_BURST:      prdata = CFG_DATA_W'(cfg_r.min_burst_photons);
      REG_WINDOW_TICKS:   prdata = CFG_DATA_W'(cfg_r.window_ticks);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/pbsw_hist.sv]
// ----------------------------------------------------------------------------
// pbsw_hist
// Timestamp history ring: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsw_hist #(
  parameter int DEPTH = 64,
  parameter int PTR_W = 6
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [PTR_W-1:0]              waddr,
  input  wire logic [pbsw_pkg::TIME_W-1:0]   wdata,
  input  wire logic                          re,
  input  wire logic [PTR_W-1:0]              raddr,
  output logic      [pbsw_pkg::TIME_W-1:0]   rdata
);
  import pbsw_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/pbsw_front.sv]
// ----------------------------------------------------------------------------
// pbsw_front
// Input stage: numbers photons, keeps the ring write slot, works out the
// slot of the window's first photon and registers the photon for the burst
// stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsw_front #(
  parameter int MAX_WINDOW = 64,
  parameter int INDEX_BITS = 40,
  parameter int PTR_W      = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pbsw_pkg::TIME_W-1:0]   in_time,
  input  wire logic                          in_last,
  input  wire logic [pbsw_pkg::WP_W-1:0]     window_photons,
  input  wire logic                          s1_free,
  output logic                               mem_we,
  output logic      [PTR_W-1:0]              mem_waddr,
  output logic      [pbsw_pkg::TIME_W-1:0]   mem_wdata,
  output logic      [PTR_W-1:0]              mem_raddr,
  output logic                               s1_valid,
  output logic      [pbsw_pkg::TIME_W-1:0]   s1_time,
  output logic      [INDEX_BITS-1:0]         s1_idx,
  output logic      [INDEX_BITS-1:0]         s1_start,
  output pbsw_pkg::pbsw_flags_t              s1_flags
);
  import pbsw_pkg::*;

  localparam int MW = $clog2(MAX_WINDOW + 1);
  localparam int CW = (INDEX_BITS > MW) ? INDEX_BITS : MW;
  localparam int AW = PTR_W + 1;

  logic [INDEX_BITS-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]     s1_time_r;
  logic [INDEX_BITS-1:0] s1_idx_r, s1_start_r;
  pbsw_flags_t           s1_flags_r;

  logic [31:0]           wp_ext;
  logic [MW-1:0]         m_eff, m_less;
  logic [AW-1:0]         raddr_w;
  logic                  accept;
  logic                  take;
  pbsw_flags_t           flags_w;

  // Window size of zero acts as one, anything above the ring depth as the depth.
  always_comb begin
    wp_ext = 32'(window_photons);
    if (wp_ext == 32'd0) begin
      m_eff = MW'(1);
    end else if (wp_ext > 32'(MAX_WINDOW)) begin
      m_eff = MW'(MAX_WINDOW);
    end else begin
      m_eff = MW'(wp_ext);
    end
    m_less = m_eff - MW'(1);
  end

  assign take     = s1_valid_r & s1_free;
  assign in_ready = ~s1_valid_r | s1_free;
  assign accept   = in_valid & in_ready;

  always_comb begin
    if (AW'(ptr_r) >= AW'(m_less)) begin
      raddr_w = AW'(ptr_r) - AW'(m_less);
    end else begin
      raddr_w = AW'(ptr_r) + AW'(MAX_WINDOW) - AW'(m_less);
    end
  end

  assign mem_we    = accept;
  assign mem_waddr = ptr_r;
  assign mem_wdata = in_time;
  assign mem_raddr = raddr_w[PTR_W-1:0];

  assign flags_w.full  = CW'(count_r) >= CW'(m_less);
  assign flags_w.eos   = in_last;
  assign flags_w.m_one = (m_less == '0);

  always_comb begin
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
      if (in_last) begin
        count_nxt = '0;
        ptr_nxt   = '0;
      end else begin
        // The photon index sticks at its top value.
        if (!(&count_r)) begin
          count_nxt = count_r + INDEX_BITS'(1);
        end
        if (ptr_r == PTR_W'(MAX_WINDOW - 1)) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ptr_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      ptr_r      <= ptr_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_time_r  <= in_time;
      s1_idx_r   <= count_r;
      s1_start_r <= INDEX_BITS'(CW'(count_r) - CW'(m_less));
      s1_flags_r <= flags_w;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_time  = s1_time_r;
  assign s1_idx   = s1_idx_r;
  assign s1_start = s1_start_r;
  assign s1_flags = s1_flags_r;

  // An end-of-record photon restarts numbering and the ring.
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> count_r == '0 && ptr_r == '0)
    else $error("photon counter not cleared after end of record");

  // A registered photon that cannot move on must stay in place.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_free |=> s1_valid_r && $stable(s1_idx_r))
    else $error("stalled photon lost in front stage");

endmodule

`default_nettype wire

[rtl/pbsw_burst.sv]
// ----------------------------------------------------------------------------
// pbsw_burst
// Burst stage: tests the window span, opens and closes bursts, filters them
// by length and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsw_burst #(
  parameter int INDEX_BITS = 40
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pbsw_pkg::pbsw_cfg_t           cfg,
  input  wire logic                          s1_valid,
  input  wire logic [pbsw_pkg::TIME_W-1:0]   s1_time,
  input  wire logic [INDEX_BITS-1:0]         s1_idx,
  input  wire logic [INDEX_BITS-1:0]         s1_start,
  input  wire pbsw_pkg::pbsw_flags_t         s1_flags,
  input  wire logic [pbsw_pkg::TIME_W-1:0]   hist_time,
  output logic                               s1_free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [pbsw_pkg::OUT_W-1:0]    out_start,
  output logic      [pbsw_pkg::OUT_W-1:0]    out_stop
);
  import pbsw_pkg::*;

  // Burst length is counted modulo 2^64.
  localparam int LEN_W = 64;
  localparam int CMP_W = (LEN_W > MIN_W) ? LEN_W : MIN_W;

  logic                  open_r, open_nxt;
  logic [INDEX_BITS-1:0] open_start_r, open_start_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_start_r, out_stop_r;

  logic                  take;
  logic [TIME_W-1:0]     first_time, span;
  logic                  pass;
  logic [INDEX_BITS-1:0] idx_prev;
  logic [LEN_W-1:0]      len_fail, len_eos;
  logic                  long_fail, long_eos;
  logic                  open_mid;
  logic [INDEX_BITS-1:0] start_mid;
  logic                  emit;
  logic [INDEX_BITS-1:0] emit_start, emit_stop;
  logic [INDEX_BITS+OUT_W-1:0] start_ext, stop_ext;

  assign s1_free = ~out_valid_r | out_ready;
  assign take    = s1_valid & s1_free;

  assign first_time = s1_flags.m_one ? s1_time : hist_time;
  assign span       = s1_time - first_time;
  assign pass       = span <= TIME_W'(cfg.window_ticks);

  assign idx_prev  = s1_idx - INDEX_BITS'(1);
  assign len_fail  = LEN_W'(idx_prev) - LEN_W'(open_start_r) + LEN_W'(1);
  assign long_fail = CMP_W'(len_fail) >= CMP_W'(cfg.min_burst_photons);

  // Burst state after the window test, before the end-of-record close.
  assign open_mid  = s1_flags.full ? pass : open_r;
  assign start_mid = (s1_flags.full && pass && !open_r) ? s1_start : open_start_r;
  assign len_eos   = LEN_W'(s1_idx) - LEN_W'(start_mid) + LEN_W'(1);
  assign long_eos  = CMP_W'(len_eos) >= CMP_W'(cfg.min_burst_photons);

  always_comb begin
    open_nxt       = open_r;
    open_start_nxt = open_start_r;
    emit           = 1'b0;
    emit_start     = open_start_r;
    emit_stop      = idx_prev;
    if (take) begin
      open_nxt       = open_mid;
      open_start_nxt = start_mid;
      if (s1_flags.full && !pass && open_r) begin
        emit = long_fail;
      end
      if (s1_flags.eos) begin
        if (open_mid) begin
          emit       = long_eos;
          emit_start = start_mid;
          emit_stop  = s1_idx;
        end
        open_nxt       = 1'b0;
        open_start_nxt = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign start_ext = {{OUT_W{1'b0}}, emit_start};
  assign stop_ext  = {{OUT_W{1'b0}}, emit_stop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r       <= 1'b0;
      open_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      open_r       <= open_nxt;
      open_start_r <= open_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_start_r <= start_ext[OUT_W-1:0];
      out_stop_r  <= stop_ext[OUT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_start = out_start_r;
  assign out_stop  = out_stop_r;

  // No burst may survive the end of a record.
  a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    take && s1_flags.eos |=> !open_r)
    else $error("burst still open after end of record");

  // A new result appears only for a photon that was processed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take))
    else $error("result appeared without a processed photon");

endmodule

`default_nettype wire

[rtl/photon_burst_sliding_window_unit.sv]
// ----------------------------------------------------------------------------
// photon_burst_sliding_window_unit
// Sliding-window burst search over a stream of photon arrival timestamps.
// ----------------------------------------------------------------------------
// The unit takes one photon timestamp per clock while no held result stalls
// it, and numbers the photons from zero. Once window_photons photons have
// arrived it checks whether the last window_photons of them span no more than
// window_ticks; a passing window opens a burst at its first photon, a failing
// one closes an open burst at the previous photon, and the photon flagged with
// tlast closes any open burst and restarts numbering. Bursts of at least
// min_burst_photons photons come out as a start and stop index. Throughput is
// one photon per cycle while the output is not held; the photon and its
// history read are registered together, and the window test and burst logic
// sit between that register and the output register that holds a reported
// burst. A result held by the receiver stalls the input. Configuration is to
// be written by the user over the APB port only while no photon is in flight;
// the block itself does not enforce this.
`default_nettype none

module photon_burst_sliding_window_unit #(
  parameter int MAX_WINDOW = 64,
  parameter int INDEX_BITS = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [63:0] macro_time; in_tlast: end_of_stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tlast,
  // out_tdata: [39:0] burst_start, [79:40] burst_stop
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pbsw_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  pbsw_cfg_t             cfg;
  logic                  s1_free;
  logic                  mem_we;
  logic [PTR_W-1:0]      mem_waddr, mem_raddr;
  logic [TIME_W-1:0]     mem_wdata, hist_time;
  logic                  s1_valid;
  logic [TIME_W-1:0]     s1_time;
  logic [INDEX_BITS-1:0] s1_idx, s1_start;
  pbsw_flags_t           s1_flags;
  logic [OUT_W-1:0]      burst_start, burst_stop;

  pbsw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pbsw_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .INDEX_BITS (INDEX_BITS),
    .PTR_W      (PTR_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_time        (in_tdata),
    .in_last        (in_tlast),
    .window_photons (cfg.window_photons),
    .s1_free        (s1_free),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .s1_valid       (s1_valid),
    .s1_time        (s1_time),
    .s1_idx         (s1_idx),
    .s1_start       (s1_start),
    .s1_flags       (s1_flags)
  );

  // The history read is issued with the write of each accepted photon.
  pbsw_hist #(
    .DEPTH (MAX_WINDOW),
    .PTR_W (PTR_W)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_we),
    .raddr (mem_raddr),
    .rdata (hist_time)
  );

  pbsw_burst #(
    .INDEX_BITS (INDEX_BITS)
  ) u_burst (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_time   (s1_time),
    .s1_idx    (s1_idx),
    .s1_start  (s1_start),
    .s1_flags  (s1_flags),
    .hist_time (hist_time),
    .s1_free   (s1_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_start (burst_start),
    .out_stop  (burst_stop)
  );

  assign out_tdata = {burst_stop, burst_start};

endmodule

`default_nettype wire

[verif/pbsw_burst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsw_burst_checker
// Watches the photon, burst and register ports of the sliding-window burst
// search, predicts every reported burst from the accepted photons and the
// written registers, and compares each burst that leaves the block field by
// field with the oldest prediction. Register reads are checked as well.
// ----------------------------------------------------------------------------
module pbsw_burst_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [63:0]                     in_tdata,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [79:0]                     out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pbsw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pbsw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [pbsw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              pending,
  output int                              bursts_seen
);
  import pbsw_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam logic [OUT_W-1:0] TALLY_MAX = '1;

  typedef struct packed {
    logic [OUT_W-1:0] last_idx;
    logic [OUT_W-1:0] first_idx;
  } burst_t;

  logic [WP_W-1:0]    win_photons;
  logic [MIN_W-1:0]   min_len;
  logic [TICKS_W-1:0] win_ticks;

  logic [TIME_W-1:0]  stamp_ring [RING_DEPTH];
  logic [OUT_W-1:0]   photon_tally;
  logic [OUT_W-1:0]   open_first;
  logic               burst_is_open;
  int                 ring_wr;

  burst_t             expected_bursts[$];
  int                 fail_tally = 0;
  int                 seen_tally = 0;

  task automatic flag_mismatch(input string msg);
    fail_tally++;
    if (fail_tally <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic restart_record();
    for (int i = 0; i < RING_DEPTH; i++) stamp_ring[i] = '0;
    photon_tally  = '0;
    burst_is_open = 1'b0;
    open_first    = '0;
    ring_wr       = 0;
  endtask

  // A closed burst is only reported when it is long enough.
  task automatic close_burst(input logic [OUT_W-1:0] first_idx,
                             input logic [OUT_W-1:0] last_idx);
    logic [63:0] length;
    burst_t b;
    length = 64'(last_idx) - 64'(first_idx) + 64'd1;
    if (length >= 64'(min_len)) begin
      b.first_idx = first_idx;
      b.last_idx  = last_idx;
      expected_bursts = {expected_bursts, b};
    end
  endtask

  task automatic advance_photon(input logic [TIME_W-1:0] stamp, input logic is_last);
    int unsigned win;
    int unsigned first_slot;
    logic [63:0] span;
    if (win_photons == 0) win = 1;
    else if (win_photons > RING_DEPTH) win = RING_DEPTH;
    else win = win_photons;

    stamp_ring[ring_wr] = stamp;
    if (64'(photon_tally) >= 64'(win - 1)) begin
      first_slot = (ring_wr + RING_DEPTH - (win - 1)) % RING_DEPTH;
      // The span wraps modulo 2^64, so an earlier timestamp fails the window.
      span = stamp - stamp_ring[first_slot];
      if (span <= 64'(win_ticks)) begin
        if (!burst_is_open) begin
          burst_is_open = 1'b1;
          open_first    = photon_tally - OUT_W'(win - 1);
        end
      end else if (burst_is_open) begin
        burst_is_open = 1'b0;
        close_burst(open_first, photon_tally - OUT_W'(1));
      end
    end

    if (is_last) begin
      if (burst_is_open) close_burst(open_first, photon_tally);
      restart_record();
    end else begin
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      if (photon_tally != TALLY_MAX) photon_tally = photon_tally + OUT_W'(1);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [REG_SEL_W-1:0] sel);
    case (sel)
      REG_WINDOW_PHOTONS: return CFG_DATA_W'(win_photons);
      REG_MIN_BURST:      return CFG_DATA_W'(min_len);
      REG_WINDOW_TICKS:   return CFG_DATA_W'(win_ticks);
      default:            return '0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [REG_SEL_W-1:0] sel;
    burst_t want;
    logic [OUT_W-1:0] got_first;
    logic [OUT_W-1:0] got_last;
    if (!rst_n) begin
      win_photons = RST_WINDOW_PHOTONS;
      min_len     = RST_MIN_BURST;
      win_ticks   = RST_WINDOW_TICKS;
      restart_record();
      expected_bursts.delete();
    end else begin
      sel = cfg_paddr[4:3];
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (sel)
            REG_WINDOW_PHOTONS: win_photons = cfg_pwdata[WP_W-1:0];
            REG_MIN_BURST:      min_len     = cfg_pwdata[MIN_W-1:0];
            REG_WINDOW_TICKS:   win_ticks   = cfg_pwdata[TICKS_W-1:0];
            default: ;
          endcase
        end else if (cfg_prdata !== reg_value(sel)) begin
          flag_mismatch($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                                  sel, reg_value(sel), cfg_prdata));
        end
      end

      // Predictions go to the back of the queue, so adding them before the
      // comparison never disturbs the oldest entry.
      if (in_tvalid && in_tready) advance_photon(in_tdata, in_tlast);

      if (out_tvalid && out_tready) begin
        got_first = out_tdata[39:0];
        got_last  = out_tdata[79:40];
        seen_tally++;
        if (expected_bursts.size() == 0) begin
          flag_mismatch($sformatf("burst %0d..%0d came out with none expected",
                                  got_first, got_last));
        end else begin
          want = expected_bursts.pop_front();
          if (got_first !== want.first_idx)
            flag_mismatch($sformatf("burst_start: expected %0d, got %0d",
                                    want.first_idx, got_first));
          if (got_last !== want.last_idx)
            flag_mismatch($sformatf("burst_stop: expected %0d, got %0d",
                                    want.last_idx, got_last));
        end
      end
    end
    pending     <= expected_bursts.size();
    mismatches  <= fail_tally;
    bursts_seen <= seen_tally;
  end

endmodule

[verif/photon_burst_sliding_window_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// photon_burst_sliding_window_unit_tb
// Feeds photon records through the sliding-window burst search under a series
// of register settings, from short directed records to long random ones with
// dense and sparse stretches, while both stream sides idle at random. The
// checker beside the block predicts and compares every burst.
// ----------------------------------------------------------------------------
module photon_burst_sliding_window_unit_tb;
  import pbsw_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [79:0]           out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int pending;
  int bursts_seen;
  int photons_sent   = 0;
  int records_sent   = 0;
  int settings_used  = 1;
  int burst_left     = 0;
  int gap_left       = 0;
  bit hold_off_req   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  photon_burst_sliding_window_unit #(
    .MAX_WINDOW(64),
    .INDEX_BITS(40)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  pbsw_burst_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending),
    .bursts_seen (bursts_seen)
  );

  // Leaves psel high; the caller drops it after the last access.
  task automatic apb_access(input logic [REG_SEL_W-1:0] sel, input logic wr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic set_config(input logic [WP_W-1:0] wp, input logic [MIN_W-1:0] mb,
                            input logic [TICKS_W-1:0] wt);
    apb_access(REG_WINDOW_PHOTONS, 1'b1, CFG_DATA_W'(wp));
    apb_access(REG_MIN_BURST, 1'b1, CFG_DATA_W'(mb));
    apb_access(REG_WINDOW_TICKS, 1'b1, CFG_DATA_W'(wt));
    apb_access(REG_WINDOW_PHOTONS, 1'b0, '0);
    apb_access(REG_MIN_BURST, 1'b0, '0);
    apb_access(REG_WINDOW_TICKS, 1'b0, '0);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings_used++;
  endtask

  // Photons that close no burst may still be in the pipeline once the queue
  // of expected bursts is empty, so the task keeps waiting before returning.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_photon(input logic [63:0] stamp, input logic is_last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= stamp;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    photons_sent++;
  endtask

  // Records alternate dense stretches, which pass the window test, with
  // sparse ones, which fail it; a few photons jump to random or earlier times.
  task automatic run_phase(input logic [WP_W-1:0] wp, input logic [MIN_W-1:0] mb,
                           input logic [TICKS_W-1:0] wt, input int target,
                           input bit dense_results);
    int          m_eff;
    int          rec_len;
    int          sent;
    int          stretch;
    bit          dense;
    logic [63:0] stamp;
    logic [31:0] dense_max;
    settle();
    set_config(wp, mb, wt);
    if (dense_results) hold_off_req = 1'b1;
    if (wp == 0) m_eff = 1;
    else if (wp > 64) m_eff = 64;
    else m_eff = wp;
    dense_max = wt / m_eff;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) rec_len = $urandom_range(1, m_eff);
      else rec_len = $urandom_range(m_eff, 3 * m_eff + 30);
      stamp = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) stamp = ~64'd0 - $urandom_range(0, 4000);
      dense   = $urandom_range(0, 1);
      stretch = 0;
      for (int i = 0; i < rec_len; i++) begin
        if (stretch == 0) begin
          dense = !dense;
          if (dense_results) stretch = $urandom_range(1, 2);
          else if (dense) stretch = $urandom_range(1, 2 * m_eff + 8);
          else stretch = $urandom_range(1, m_eff + 4);
        end
        stretch--;
        if ($urandom_range(0, 24) == 0)
          stamp = $urandom_range(0, 1) ? {$urandom, $urandom} : stamp - $urandom_range(1, 1000);
        else if (dense)
          stamp = stamp + $urandom_range(0, dense_max);
        else
          stamp = stamp + 64'(wt) + 64'd1 + $urandom_range(0, 1000);
        send_photon(stamp, i == rec_len - 1);
      end
      sent += rec_len;
      records_sent++;
    end
  endtask

  // Receiver: runs of steady, lightly and heavily stalled acceptance, plus
  // one long hold-off on request so that the block backs up into its input.
  initial begin : result_sink
    int run_len;
    int mode;
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 2);
        run_len = $urandom_range(1, 40);
        repeat (run_len) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 3) != 0);
            default: out_tready <= ($urandom_range(0, 1) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a record shorter than the window, timestamps at both ends.
    send_photon(64'd0, 1'b0);
    send_photon(~64'd0, 1'b0);
    send_photon(64'd5, 1'b1);
    records_sent++;

    // A window of zero photons acts as one, and a minimum of zero reports all.
    settle();
    set_config(7'd0, 40'd0, 32'd0);
    send_photon(64'd7, 1'b0);
    send_photon(64'd7, 1'b0);
    send_photon(64'd7, 1'b1);
    send_photon(64'd1, 1'b0);
    send_photon(64'd2, 1'b1);
    records_sent += 2;

    // Span exactly at the limit, a failing window, a backward timestamp and
    // a burst still open at the end of the record.
    settle();
    set_config(7'd3, 40'd2, 32'd10);
    send_photon(64'd100, 1'b0);
    send_photon(64'd105, 1'b0);
    send_photon(64'd110, 1'b0);
    send_photon(64'd121, 1'b0);
    send_photon(64'd122, 1'b0);
    send_photon(64'd123, 1'b0);
    send_photon(64'd50, 1'b0);
    send_photon(64'd51, 1'b0);
    send_photon(64'd52, 1'b1);
    records_sent++;

    run_phase(7'd3, 40'd2, 32'd50, 110, 1'b0);
    run_phase(7'd10, 40'd30, 32'd1000, 120, 1'b0);
    run_phase(7'd2, 40'd1, 32'd10, 150, 1'b1);
    run_phase(7'd64, 40'd5, 32'd5000, 170, 1'b0);
    run_phase(7'd127, 40'd3, 32'd2000, 100, 1'b0);
    run_phase(7'd0, 40'd0, 32'd0, 60, 1'b0);
    run_phase(7'd4, 40'd1, 32'd0, 80, 1'b0);
    run_phase(7'd5, '1, '1, 60, 1'b0);
    run_phase(7'd7, 40'd4, 32'd300, 90, 1'b0);

    settle();
    $display("Run covered %0d photons in %0d records under %0d register settings.",
             photons_sent, records_sent, settings_used);
    $display("%0d bursts were compared, including a stretch of output backpressure.",
             bursts_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
